FILE: hw/rtl/lpht_pkg.sv
// Package: shared constants, types and codes of the hash table.
`timescale 1ns / 1ps
`default_nettype none
package lpht_pkg;
	localparam int TableSlotsDef = 256;
	localparam int KeyBitsDef    = 64;
	localparam int ValueBitsDef  = 32;
	localparam logic [7:0] LoadLimitReset = 8'd192;

	typedef enum logic [1:0] {
		ACT_INSERT  = 2'd0,
		ACT_REPLACE = 2'd1,
		ACT_DELETE  = 2'd2,
		ACT_LOOKUP  = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_EXISTS   = 2'd1,
		ST_NOTFOUND = 2'd2,
		ST_FULL     = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_PRB_RD,
		S_PRB_CHK,
		S_SH_RD,
		S_SH_CHK,
		S_DONE
	} fsm_t;
endpackage
`default_nettype wire

FILE: hw/rtl/linear_probe_hash_table.sv
// Top level: linear-probing hash table with backward-shift delete.
// Probing walks slots in S_PRB_RD and S_PRB_CHK; a delete then walks slots in S_SH_RD and S_SH_CHK.
// Throughput: one item at a time; busy stays high through the result cycle.
// Each visited slot takes a memory read state and a check state.
// Reset: a clearing pass (S_CLEAR) empties all slots in turn; busy is high.
// Results appear on done for one cycle; the receiver cannot stall.
`timescale 1ns / 1ps
`default_nettype none
module linear_probe_hash_table import lpht_pkg::*; #(
	parameter int TABLE_SLOTS = TableSlotsDef,
	parameter int KEY_BITS    = KeyBitsDef,
	parameter int VALUE_BITS  = ValueBitsDef
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [1:0]  action,
	input  wire logic [63:0] key,
	input  wire logic [63:0] key_hash,
	input  wire logic [31:0] value,
	output logic             done,
	output logic [1:0]       status,
	output logic [31:0]      value_out,
	output logic [7:0]       slot_index,
	output logic [7:0]       entry_count,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [1:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);
	localparam int AW = $clog2(TABLE_SLOTS);
	localparam int EW = 1 + KEY_BITS + VALUE_BITS + AW;
	localparam int VW = (VALUE_BITS < 32) ? VALUE_BITS : 32;
	localparam int SW = (AW < 8) ? AW : 8;
	localparam logic [AW-1:0] LAST = AW'(TABLE_SLOTS - 1);

	fsm_t state_q, state_d;
	logic [7:0]  limit_q, count_q;
	logic [1:0]  act_q;
	logic [KEY_BITS-1:0] key_q;
	logic [VALUE_BITS-1:0] val_q;
	logic [AW-1:0] home_q, pos_q, hole_q, j_q, raddr;
	logic [AW:0]   n_q;
	logic [1:0]  st_q;
	logic [31:0] vout_q;
	logic [7:0]  slot_q;
	logic        we;
	logic [AW-1:0] waddr;
	logic [EW-1:0] wdata, rdata;
	logic        r_valid;
	logic [KEY_BITS-1:0] r_key;
	logic [VALUE_BITS-1:0] r_val;
	logic [AW-1:0] r_home;

	assign {r_valid, r_key, r_val, r_home} = rdata;

	lpht_store #(.TABLE_SLOTS(TABLE_SLOTS), .KEY_BITS(KEY_BITS), .VALUE_BITS(VALUE_BITS))
	u_store (.clk(clk), .raddr(raddr), .rdata(rdata), .we(we), .waddr(waddr),
		.wdata(wdata));

	assign pready = 1'b1;
	assign prdata = (paddr == 2'd0) ? {24'd0, limit_q} : 32'd0;
	assign busy = (state_q != S_IDLE);
	assign done = (state_q == S_DONE);
	assign status = st_q;
	assign value_out = vout_q;
	assign slot_index = slot_q;
	assign entry_count = count_q;

	function automatic logic [AW-1:0] nxt(input logic [AW-1:0] s);
		nxt = (s == LAST) ? '0 : s + 1'b1;
	endfunction

	logic [AW-1:0] d_home, d_hole;
	logic          in_home_walk;
	assign d_home = j_q - r_home;
	assign d_hole = j_q - hole_q;
	assign in_home_walk = (d_home >= d_hole);

	always_comb begin
		state_d = state_q;
		raddr = pos_q;
		we = 1'b0;
		waddr = pos_q;
		wdata = {1'b1, key_q, val_q, home_q};
		unique case (state_q)
			S_CLEAR: begin
				we = 1'b1;
				waddr = pos_q;
				wdata = '0;
				if (pos_q == LAST) state_d = S_IDLE;
			end
			S_IDLE: if (start) state_d = S_PRB_RD;
			S_PRB_RD: begin
				raddr = pos_q;
				state_d = S_PRB_CHK;
			end
			S_PRB_CHK: begin
				if (!r_valid) begin
					if (act_q[1] || count_q >= limit_q) begin
						state_d = S_DONE;
					end else begin
						we = 1'b1;
						waddr = pos_q;
						state_d = S_DONE;
					end
				end else if (r_key == key_q) begin
					priority case (act_q)
						ACT_REPLACE: begin
							we = 1'b1;
							wdata = {1'b1, r_key, val_q, r_home};
							state_d = S_DONE;
						end
						ACT_DELETE: state_d = S_SH_RD;
						default: state_d = S_DONE;
					endcase
				end else if (n_q == (AW+1)'(TABLE_SLOTS - 1) || n_q[AW]) begin
					state_d = S_DONE;
				end else begin
					state_d = S_PRB_RD;
				end
			end
			S_SH_RD: begin
				raddr = j_q;
				state_d = S_SH_CHK;
			end
			S_SH_CHK: begin
				if (!r_valid || n_q[AW]) begin
					we = 1'b1;
					waddr = hole_q;
					wdata = '0;
					state_d = S_DONE;
				end else begin
					if (in_home_walk) begin
						we = 1'b1;
						waddr = hole_q;
						wdata = rdata;
					end
					state_d = S_SH_RD;
				end
			end
			S_DONE: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			limit_q <= LoadLimitReset;
			count_q <= '0;
			pos_q <= '0;
			hole_q <= '0;
			j_q <= '0;
			n_q <= '0;
			st_q <= '0;
			vout_q <= '0;
			slot_q <= '0;
		end else begin
			state_q <= state_d;
			if (psel && penable && pwrite && paddr == 2'd0) limit_q <= pwdata[7:0];
			unique case (state_q)
				S_CLEAR: pos_q <= nxt(pos_q);
				S_IDLE: if (start) begin
					pos_q <= key_hash[AW-1:0];
					n_q <= '0;
				end
				S_PRB_CHK: begin
					if (!r_valid) begin
						vout_q <= '0;
						if (act_q[1]) begin
							st_q <= ST_NOTFOUND;
							slot_q <= '0;
						end else if (count_q >= limit_q) begin
							st_q <= ST_FULL;
							slot_q <= '0;
						end else begin
							st_q <= ST_OK;
							slot_q <= 8'(pos_q[SW-1:0]);
							count_q <= count_q + 1'b1;
						end
					end else if (r_key == key_q) begin
						slot_q <= 8'(pos_q[SW-1:0]);
						st_q <= (act_q == ACT_INSERT) ? ST_EXISTS : ST_OK;
						vout_q <= act_q[1] ? 32'(r_val[VW-1:0]) : 32'd0;
						hole_q <= pos_q;
						j_q <= nxt(pos_q);
						n_q <= (AW+1)'(1);
						if (act_q == ACT_DELETE && count_q != 0) count_q <= count_q - 1'b1;
					end else begin
						n_q <= n_q + 1'b1;
						pos_q <= nxt(pos_q);
						vout_q <= '0;
						slot_q <= '0;
						st_q <= act_q[1] ? ST_NOTFOUND : ST_FULL;
					end
				end
				S_SH_CHK: if (r_valid && !n_q[AW]) begin
					if (in_home_walk) hole_q <= j_q;
					j_q <= nxt(j_q);
					n_q <= (n_q + 1'b1 == (AW+1)'(TABLE_SLOTS)) ? {1'b1, {AW{1'b0}}} :
						n_q + 1'b1;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start) begin
			act_q  <= action;
			key_q  <= key[KEY_BITS-1:0];
			val_q  <= VALUE_BITS'(value);
			home_q <= key_hash[AW-1:0];
		end
	end
endmodule
`default_nettype wire

FILE: hw/rtl/lpht_store.sv
// Slot memory: valid, key, value and home per slot, registered read.
`timescale 1ns / 1ps
`default_nettype none
module lpht_store import lpht_pkg::*; #(
	parameter int TABLE_SLOTS = TableSlotsDef,
	parameter int KEY_BITS    = KeyBitsDef,
	parameter int VALUE_BITS  = ValueBitsDef,
	localparam int AW = $clog2(TABLE_SLOTS),
	localparam int EW = 1 + KEY_BITS + VALUE_BITS + AW
) (
	input  wire logic          clk,
	input  wire logic [AW-1:0] raddr,
	output logic      [EW-1:0] rdata,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [EW-1:0] wdata
);
	logic [EW-1:0] mem [TABLE_SLOTS];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire
